// ----- rtl/core/bipartite_max_matching_defines.svh -----
// Assertion macros for the bipartite matching block.
`ifndef BIPARTITE_MAX_MATCHING_DEFINES_SVH
`define BIPARTITE_MAX_MATCHING_DEFINES_SVH
`ifndef SYNTHESIS
`define BMM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("bmm check failed");
`define BMM_ASSERT_IMP(lbl, ante, cons) \
    `BMM_ASSERT(lbl, (ante) |-> (cons))
`else
`define BMM_ASSERT(lbl, prop)
`define BMM_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

// ----- rtl/core/bmm_pkg.sv -----
// Shared constants for the bipartite matching block.
`timescale 1ns / 1ps
`default_nettype none
package bmm_pkg;
    localparam int MAX_LEFT_DEF  = 1024;
    localparam int MAX_RIGHT_DEF = 1024;
    localparam int MAX_EDGES_DEF = 16384;
    localparam int VTX_W = 10;
    localparam int CNT_W = 11;
    localparam int COUNT_RESET = 1024;
    localparam logic REG_LEFT_COUNT  = 1'b0;
    localparam logic REG_RIGHT_COUNT = 1'b1;
endpackage
`default_nettype wire

// ----- rtl/core/bmm_ram.sv -----
// Simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module bmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/core/bipartite_max_matching.sv -----
// Top level: edge store and Hopcroft-Karp sequencer for maximum bipartite matching.
//   channel  dir  fields (low bit up)                      handshake
//   s_       in   tdata: left_vertex, right_vertex; tlast  tvalid/tready
//   m_       out  tdata: matching_size, unmatched_left;    tvalid/tready
//                 tuser: edge_dropped
//   cfg_     in   index 0 left_count, 1 right_count        cfg_we
// Edges load at one per cycle; the head read-modify-write forwards between
// back-to-back edges. The last edge starts the search, which runs through the
// state memories one access per step, so its length depends on the graph.
// After reset, and after each result, a clearing pass empties all MAX_LEFT
// adjacency heads before edges are taken. A waiting result holds the
// sequencer before that pass.
`timescale 1ns / 1ps
`default_nettype none
`include "bipartite_max_matching_defines.svh"
module bipartite_max_matching #(
    parameter int MAX_LEFT  = bmm_pkg::MAX_LEFT_DEF,
    parameter int MAX_RIGHT = bmm_pkg::MAX_RIGHT_DEF,
    parameter int MAX_EDGES = bmm_pkg::MAX_EDGES_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [23:0]               s_tdata,   // left_vertex, right_vertex
    input  wire logic                      s_tlast,   // last_edge
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic      [23:0]               m_tdata,   // matching_size, unmatched_left
    output logic                           m_tuser,   // edge_dropped
    input  wire logic                      cfg_we,
    input  wire logic                      cfg_index,
    input  wire logic [bmm_pkg::CNT_W-1:0] cfg_data
);
    localparam int LW  = $clog2(MAX_LEFT);
    localparam int RW  = $clog2(MAX_RIGHT);
    localparam int EW  = $clog2(MAX_EDGES);
    localparam int PW  = EW + 1;
    localparam int CLW = LW + 1;
    localparam int CRW = RW + 1;
    localparam int DW  = LW + 1;
    localparam int NW  = LW + 1;
    localparam int IW  = (CLW > CRW) ? CLW : CRW;
    localparam int FW  = LW + PW;
    localparam int VW  = bmm_pkg::VTX_W;
    localparam int CW  = bmm_pkg::CNT_W;

    localparam logic [PW-1:0] PTR_NIL     = {PW{1'b1}};
    localparam logic [NW-1:0] PART_NONE   = {NW{1'b1}};
    localparam logic [DW-1:0] DEPTH_UNSET = {DW{1'b1}};

    localparam logic [4:0] ST_CLR  = 5'd0;
    localparam logic [4:0] ST_LOAD = 5'd1;
    localparam logic [4:0] ST_LAST = 5'd2;
    localparam logic [4:0] ST_INIT = 5'd3;
    localparam logic [4:0] ST_L0   = 5'd4;
    localparam logic [4:0] ST_L1   = 5'd5;
    localparam logic [4:0] ST_B0   = 5'd6;
    localparam logic [4:0] ST_B1   = 5'd7;
    localparam logic [4:0] ST_B2   = 5'd8;
    localparam logic [4:0] ST_B3   = 5'd9;
    localparam logic [4:0] ST_B4   = 5'd10;
    localparam logic [4:0] ST_B5   = 5'd11;
    localparam logic [4:0] ST_B6   = 5'd12;
    localparam logic [4:0] ST_A0   = 5'd13;
    localparam logic [4:0] ST_A1   = 5'd14;
    localparam logic [4:0] ST_S0   = 5'd15;
    localparam logic [4:0] ST_P1   = 5'd16;
    localparam logic [4:0] ST_P2   = 5'd17;
    localparam logic [4:0] ST_S1   = 5'd18;
    localparam logic [4:0] ST_S2   = 5'd19;
    localparam logic [4:0] ST_S3   = 5'd20;
    localparam logic [4:0] ST_S4   = 5'd21;
    localparam logic [4:0] ST_W0   = 5'd22;
    localparam logic [4:0] ST_WC   = 5'd23;
    localparam logic [4:0] ST_W1   = 5'd24;
    localparam logic [4:0] ST_W2   = 5'd25;
    localparam logic [4:0] ST_DONE = 5'd26;

    logic [4:0]     state_reg, state_next;
    logic [IW-1:0]  i_reg, i_next;
    logic [CLW-1:0] qn_reg, qn_next, qi_reg, qi_next, u_reg, u_next;
    logic [CLW-1:0] total_reg, total_next, found_reg, found_next;
    logic [CLW-1:0] sp_reg, sp_next, k_reg, k_next;
    logic [LW-1:0]  top_u_reg, top_u_next, u2_reg, u2_next, fu_reg, fu_next;
    logic [PW-1:0]  top_e_reg, top_e_next, link_reg, link_next;
    logic [RW-1:0]  v_reg, v_next;
    logic [DW-1:0]  d1_reg, d1_next, du_reg, du_next;
    logic [PW-1:0]  edge_total_reg, edge_total_next;
    logic           drop_reg, drop_next;
    logic [CW-1:0]  left_count_reg, right_count_reg;
    logic           s1_valid_reg;
    logic [VW-1:0]  s1_u_reg, s1_v_reg;
    logic           fwd_valid_reg;
    logic [LW-1:0]  fwd_u_reg;
    logic [PW-1:0]  fwd_ptr_reg;
    logic           m_tvalid_reg, m_tvalid_next;
    logic [CW-1:0]  m_size_reg, m_size_next, m_unm_reg, m_unm_next;
    logic           m_drop_reg, m_drop_next;

    logic [CLW-1:0] eff_left;
    logic [CRW-1:0] eff_right;

    logic              e_we, h_we, p_we, t_we, d_we, f_we, q_we, k_we;
    logic [EW-1:0]     e_wa, e_ra;
    logic [RW+PW-1:0]  e_wd, e_rd;
    logic [LW-1:0]     h_wa, h_ra, t_wa, t_ra, d_wa, d_ra, f_wa, f_ra, q_wa, q_ra;
    logic [PW-1:0]     h_wd, h_rd;
    logic [RW-1:0]     p_wa, p_ra;
    logic [NW-1:0]     p_wd, p_rd;
    logic              t_wd, t_rd, f_wd, f_rd;
    logic [DW-1:0]     d_wd, d_rd;
    logic [LW-1:0]     q_wd, q_rd;
    logic [LW-1:0]     k_wa, k_ra;
    logic [FW-1:0]     k_wd, k_rd;

    logic           s_accept;
    logic [31:0]    s_u_ext;
    logic [31:0]    s1_u_ext, s1_v_ext;
    logic           s1_drop, s1_write;
    logic [PW-1:0]  s1_head;
    logic [RW-1:0]  e_target;
    logic [PW-1:0]  e_link;
    logic [LW-1:0]  k_fu;
    logic [PW-1:0]  k_fe;
    logic [31:0]    tmp32;

    assign eff_left  = CLW'((32'(left_count_reg) > MAX_LEFT) ? MAX_LEFT
                            : 32'(left_count_reg));
    assign eff_right = CRW'((32'(right_count_reg) > MAX_RIGHT) ? MAX_RIGHT
                            : 32'(right_count_reg));

    assign s_tready = (state_reg == ST_LOAD);
    assign s_accept = s_tvalid && s_tready;
    assign s_u_ext  = 32'(s_tdata[VW-1:0]);
    assign s1_u_ext = 32'(s1_u_reg);
    assign s1_v_ext = 32'(s1_v_reg);
    assign s1_drop  = (s1_u_ext >= 32'(eff_left)) || (s1_v_ext >= 32'(eff_right)) ||
                      (32'(edge_total_reg) >= MAX_EDGES);
    assign s1_write = s1_valid_reg && !s1_drop;
    assign s1_head  = (fwd_valid_reg && (fwd_u_reg == s1_u_ext[LW-1:0])) ? fwd_ptr_reg
                      : h_rd;
    assign e_target = e_rd[RW+PW-1:PW];
    assign e_link   = e_rd[PW-1:0];
    assign k_fu     = k_rd[FW-1:PW];
    assign k_fe     = k_rd[PW-1:0];

    always_comb begin
        state_next      = state_reg;
        i_next          = i_reg;
        qn_next         = qn_reg;
        qi_next         = qi_reg;
        u_next          = u_reg;
        total_next      = total_reg;
        found_next      = found_reg;
        sp_next         = sp_reg;
        k_next          = k_reg;
        top_u_next      = top_u_reg;
        top_e_next      = top_e_reg;
        link_next       = link_reg;
        u2_next         = u2_reg;
        fu_next         = fu_reg;
        v_next          = v_reg;
        d1_next         = d1_reg;
        du_next         = du_reg;
        edge_total_next = edge_total_reg;
        drop_next       = drop_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_size_next     = m_size_reg;
        m_unm_next      = m_unm_reg;
        m_drop_next     = m_drop_reg;
        tmp32           = 32'd0;

        e_we = 1'b0; e_wa = edge_total_reg[EW-1:0];
        e_wd = {s1_v_ext[RW-1:0], s1_head}; e_ra = top_e_reg[EW-1:0];
        h_we = 1'b0; h_wa = s1_u_ext[LW-1:0]; h_wd = edge_total_reg; h_ra = top_u_reg;
        p_we = 1'b0; p_wa = v_reg; p_wd = NW'(top_u_reg); p_ra = v_reg;
        t_we = 1'b0; t_wa = top_u_reg; t_wd = 1'b1; t_ra = u_reg[LW-1:0];
        d_we = 1'b0; d_wa = u2_reg; d_wd = d1_reg + 1'b1; d_ra = top_u_reg;
        f_we = 1'b0; f_wa = u2_reg; f_wd = 1'b1; f_ra = u2_reg;
        q_we = 1'b0; q_wa = qn_reg[LW-1:0]; q_wd = u2_reg; q_ra = qi_reg[LW-1:0];
        k_we = 1'b0; k_wa = LW'(sp_reg - 1'b1); k_wd = {top_u_reg, top_e_reg};
        k_ra = LW'(sp_reg - 2'd2);

        if (s1_valid_reg) begin
            if (s1_drop) begin
                drop_next = 1'b1;
            end else begin
                e_we = 1'b1;
                h_we = 1'b1;
                edge_total_next = edge_total_reg + 1'b1;
            end
        end

        unique case (state_reg)
            ST_CLR: begin
                h_we = 1'b1;
                h_wa = i_reg[LW-1:0];
                h_wd = PTR_NIL;
                edge_total_next = '0;
                drop_next = 1'b0;
                i_next = i_reg + 1'b1;
                if (32'(i_reg) == MAX_LEFT - 1) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                h_ra = s_u_ext[LW-1:0];
                if (s_accept && s_tlast) begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST: begin
                i_next = '0;
                state_next = ST_INIT;
            end
            ST_INIT: begin
                if ((32'(i_reg) >= 32'(eff_left)) && (32'(i_reg) >= 32'(eff_right))) begin
                    i_next = '0;
                    qn_next = '0;
                    total_next = '0;
                    state_next = ST_L0;
                end else begin
                    tmp32 = 32'(i_reg);
                    t_we = (32'(i_reg) < 32'(eff_left));
                    t_wa = tmp32[LW-1:0];
                    t_wd = 1'b0;
                    p_we = (32'(i_reg) < 32'(eff_right));
                    p_wa = tmp32[RW-1:0];
                    p_wd = PART_NONE;
                    i_next = i_reg + 1'b1;
                end
            end
            ST_L0: begin
                tmp32 = 32'(i_reg);
                t_ra = tmp32[LW-1:0];
                if (32'(i_reg) >= 32'(eff_left)) begin
                    qi_next = '0;
                    state_next = ST_B0;
                end else begin
                    state_next = ST_L1;
                end
            end
            ST_L1: begin
                tmp32 = 32'(i_reg);
                d_we = 1'b1;
                d_wa = tmp32[LW-1:0];
                d_wd = t_rd ? DEPTH_UNSET : '0;
                f_we = 1'b1;
                f_wa = tmp32[LW-1:0];
                f_wd = 1'b0;
                if (!t_rd) begin
                    q_we = 1'b1;
                    q_wd = tmp32[LW-1:0];
                    qn_next = qn_reg + 1'b1;
                end
                i_next = i_reg + 1'b1;
                state_next = ST_L0;
            end
            ST_B0: begin
                if (qi_reg >= qn_reg) begin
                    u_next = '0;
                    found_next = '0;
                    state_next = ST_A0;
                end else begin
                    state_next = ST_B1;
                end
            end
            ST_B1: begin
                h_ra = q_rd;
                d_ra = q_rd;
                state_next = ST_B2;
            end
            ST_B2: begin
                top_e_next = h_rd;
                d1_next = d_rd;
                state_next = ST_B3;
            end
            ST_B3: begin
                if (32'(top_e_reg) >= MAX_EDGES) begin
                    qi_next = qi_reg + 1'b1;
                    state_next = ST_B0;
                end else begin
                    state_next = ST_B4;
                end
            end
            ST_B4: begin
                link_next = e_link;
                v_next = e_target;
                p_ra = e_target;
                if (32'(e_target) >= 32'(eff_right)) begin
                    top_e_next = e_link;
                    state_next = ST_B3;
                end else begin
                    state_next = ST_B5;
                end
            end
            ST_B5: begin
                u2_next = p_rd[LW-1:0];
                d_ra = p_rd[LW-1:0];
                if (32'(p_rd) < 32'(eff_left)) begin
                    state_next = ST_B6;
                end else begin
                    top_e_next = link_reg;
                    state_next = ST_B3;
                end
            end
            ST_B6: begin
                if ((d_rd == DEPTH_UNSET) && (32'(qn_reg) < MAX_LEFT)) begin
                    d_we = 1'b1;
                    q_we = 1'b1;
                    qn_next = qn_reg + 1'b1;
                end
                top_e_next = link_reg;
                state_next = ST_B3;
            end
            ST_A0: begin
                h_ra = u_reg[LW-1:0];
                if (32'(u_reg) >= 32'(eff_left)) begin
                    if (found_reg == '0) begin
                        state_next = ST_DONE;
                    end else begin
                        total_next = total_reg + found_reg;
                        i_next = '0;
                        qn_next = '0;
                        state_next = ST_L0;
                    end
                end else begin
                    state_next = ST_A1;
                end
            end
            ST_A1: begin
                if (t_rd) begin
                    u_next = u_reg + 1'b1;
                    state_next = ST_A0;
                end else begin
                    f_we = 1'b1;
                    f_wa = u_reg[LW-1:0];
                    top_u_next = u_reg[LW-1:0];
                    top_e_next = h_rd;
                    sp_next = CLW'(1);
                    state_next = ST_S0;
                end
            end
            ST_S0: begin
                if (32'(top_e_reg) >= MAX_EDGES) begin
                    sp_next = sp_reg - 1'b1;
                    if (sp_reg == CLW'(1)) begin
                        u_next = u_reg + 1'b1;
                        state_next = ST_A0;
                    end else begin
                        state_next = ST_P1;
                    end
                end else begin
                    state_next = ST_S1;
                end
            end
            ST_P1: begin
                top_u_next = k_fu;
                e_ra = k_fe[EW-1:0];
                state_next = ST_P2;
            end
            ST_P2: begin
                top_e_next = e_link;
                state_next = ST_S0;
            end
            ST_S1: begin
                link_next = e_link;
                v_next = e_target;
                p_ra = e_target;
                if (32'(e_target) >= 32'(eff_right)) begin
                    top_e_next = e_link;
                    state_next = ST_S0;
                end else begin
                    state_next = ST_S2;
                end
            end
            ST_S2: begin
                du_next = d_rd;
                u2_next = p_rd[LW-1:0];
                d_ra = p_rd[LW-1:0];
                f_ra = p_rd[LW-1:0];
                if (p_rd == PART_NONE) begin
                    state_next = ST_W0;
                end else if (32'(p_rd) < 32'(eff_left)) begin
                    state_next = ST_S3;
                end else begin
                    top_e_next = link_reg;
                    state_next = ST_S0;
                end
            end
            ST_S3: begin
                h_ra = u2_reg;
                if (!f_rd && ({1'b0, d_rd} == ({1'b0, du_reg} + 1'b1)) &&
                    (32'(sp_reg) < MAX_LEFT)) begin
                    f_we = 1'b1;
                    k_we = 1'b1;
                    top_u_next = u2_reg;
                    state_next = ST_S4;
                end else begin
                    top_e_next = link_reg;
                    state_next = ST_S0;
                end
            end
            ST_S4: begin
                top_e_next = h_rd;
                sp_next = sp_reg + 1'b1;
                state_next = ST_S0;
            end
            ST_W0: begin
                p_we = 1'b1;
                t_we = 1'b1;
                k_next = sp_reg - 1'b1;
                state_next = ST_WC;
            end
            ST_WC: begin
                k_ra = LW'(k_reg - 1'b1);
                if (k_reg == '0) begin
                    found_next = found_reg + 1'b1;
                    u_next = u_reg + 1'b1;
                    state_next = ST_A0;
                end else begin
                    k_next = k_reg - 1'b1;
                    state_next = ST_W1;
                end
            end
            ST_W1: begin
                fu_next = k_fu;
                e_ra = k_fe[EW-1:0];
                state_next = ST_W2;
            end
            ST_W2: begin
                p_we = 1'b1;
                p_wa = e_target;
                p_wd = NW'(fu_reg);
                t_we = 1'b1;
                t_wa = fu_reg;
                state_next = ST_WC;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    tmp32 = 32'(total_reg);
                    m_size_next = tmp32[CW-1:0];
                    tmp32 = 32'(eff_left - total_reg);
                    m_unm_next = tmp32[CW-1:0];
                    m_drop_next = drop_reg;
                    i_next = '0;
                    state_next = ST_CLR;
                end
            end
            default: begin
                state_next = ST_CLR;
                i_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLR;
            i_reg           <= '0;
            edge_total_reg  <= '0;
            drop_reg        <= 1'b0;
            left_count_reg  <= CW'(bmm_pkg::COUNT_RESET);
            right_count_reg <= CW'(bmm_pkg::COUNT_RESET);
            s1_valid_reg    <= 1'b0;
            fwd_valid_reg   <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            i_reg          <= i_next;
            edge_total_reg <= edge_total_next;
            drop_reg       <= drop_next;
            s1_valid_reg   <= s_accept;
            fwd_valid_reg  <= s1_write;
            m_tvalid_reg   <= m_tvalid_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    bmm_pkg::REG_LEFT_COUNT:  left_count_reg  <= cfg_data;
                    bmm_pkg::REG_RIGHT_COUNT: right_count_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        qn_reg      <= qn_next;
        qi_reg      <= qi_next;
        u_reg       <= u_next;
        total_reg   <= total_next;
        found_reg   <= found_next;
        sp_reg      <= sp_next;
        k_reg       <= k_next;
        top_u_reg   <= top_u_next;
        top_e_reg   <= top_e_next;
        link_reg    <= link_next;
        u2_reg      <= u2_next;
        fu_reg      <= fu_next;
        v_reg       <= v_next;
        d1_reg      <= d1_next;
        du_reg      <= du_next;
        m_size_reg  <= m_size_next;
        m_unm_reg   <= m_unm_next;
        m_drop_reg  <= m_drop_next;
        s1_u_reg    <= s_tdata[VW-1:0];
        s1_v_reg    <= s_tdata[2*VW-1:VW];
        fwd_u_reg   <= s1_u_ext[LW-1:0];
        fwd_ptr_reg <= edge_total_reg;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, m_unm_reg, m_size_reg};
    assign m_tuser  = m_drop_reg;

    bmm_ram #(.WIDTH(RW + PW), .DEPTH(MAX_EDGES)) u_edge_ram (
        .aclk(aclk), .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra), .rdata(e_rd)
    );
    bmm_ram #(.WIDTH(PW), .DEPTH(MAX_LEFT)) u_head_ram (
        .aclk(aclk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd)
    );
    bmm_ram #(.WIDTH(NW), .DEPTH(MAX_RIGHT)) u_partner_ram (
        .aclk(aclk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd)
    );
    bmm_ram #(.WIDTH(1), .DEPTH(MAX_LEFT)) u_taken_ram (
        .aclk(aclk), .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd)
    );
    bmm_ram #(.WIDTH(DW), .DEPTH(MAX_LEFT)) u_depth_ram (
        .aclk(aclk), .we(d_we), .waddr(d_wa), .wdata(d_wd), .raddr(d_ra), .rdata(d_rd)
    );
    bmm_ram #(.WIDTH(1), .DEPTH(MAX_LEFT)) u_seen_ram (
        .aclk(aclk), .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd)
    );
    bmm_ram #(.WIDTH(LW), .DEPTH(MAX_LEFT)) u_queue_ram (
        .aclk(aclk), .we(q_we), .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd)
    );
    bmm_ram #(.WIDTH(FW), .DEPTH(MAX_LEFT)) u_stack_ram (
        .aclk(aclk), .we(k_we), .waddr(k_wa), .wdata(k_wd), .raddr(k_ra), .rdata(k_rd)
    );

    `BMM_ASSERT(a_last_stops_input, (s_accept && s_tlast) |=> !s_tready)
    `BMM_ASSERT_IMP(a_queue_order, (state_reg == ST_B3), (qi_reg < qn_reg))
    `BMM_ASSERT_IMP(a_stack_nonempty, (state_reg == ST_S0), (sp_reg != '0))
    `BMM_ASSERT_IMP(a_fwd_follows_write, fwd_valid_reg, $past(s1_write))
endmodule
`default_nettype wire
